### hdl/dnr_pkg.sv
`timescale 1ns / 1ps

package dnr_pkg;

	localparam int WIDE_BITS_DEF = 192;
	localparam int MAX_SCALE_DEF = 28;
	localparam int IN_BITS       = 192;  // three 64-bit input words
	localparam int RES_BITS      = 96;
	localparam int LOW_NIB       = RES_BITS / 4;
	localparam int SCALE_W       = 8;
	localparam int RES_SCALE_W   = 5;

	localparam logic [1:0] STATUS_NORMAL = 2'd0;
	localparam logic [1:0] STATUS_POS_OV = 2'd1;
	localparam logic [1:0] STATUS_NEG_OV = 2'd2;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_LOAD,
		OP_DIV,
		OP_RND
	} dnr_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_RND,
		ST_DONE
	} dnr_state_t;

	// datapath control word, one nibble step per cycle
	typedef struct packed {
		dnr_op_t op;
		logic    first;  // first nibble of a pass
		logic    upper;  // nibble sits at bit 96 or above
	} dnr_ctl_t;

	typedef struct packed {
		logic upper_nz;  // bits at and above 96 nonzero
		logic round_up;
	} dnr_sts_t;

endpackage

### hdl/decimal_normalize_round_top.sv
`timescale 1ns / 1ps
// Decimal normalize and round.
// Input channel (in_valid / in_stall): a mantissa of up to 192 bits in three
// 64-bit words, a decimal scale and a sign. Output channel (out_valid /
// out_stall): a 96-bit mantissa, the reduced scale, the sign and a status
// (normal, positive overflow, negative overflow).
// The mantissa sits in one shift register and is divided by ten one nibble
// per cycle over N = ceil(WIDE_BITS/4) nibbles (48 at 192 bits). Items
// are processed one at a time; in_stall is high from acceptance until the
// result is moved into the output register.
// A finished result waits in the output register while the receiver
// stalls; the next item is accepted and processed meanwhile, and its
// result waits inside until the register frees up.
// Reset (arst_n low) empties the output register and returns to idle.
module decimal_normalize_round_top #(
	parameter int WIDE_BITS = dnr_pkg::WIDE_BITS_DEF,
	parameter int MAX_SCALE = dnr_pkg::MAX_SCALE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] mant_word0,
	input  logic [63:0] mant_word1,
	input  logic [63:0] mant_word2,
	input  logic [7:0]  in_scale,
	input  logic        in_sign,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] res_low,
	output logic [31:0] res_high,
	output logic [4:0]  res_scale,
	output logic        res_sign,
	output logic [1:0]  res_status
);
	import dnr_pkg::*;

	localparam int NIB = (WIDE_BITS + 3) / 4;
	localparam int W   = NIB * 4;

	logic                in_accept;
	logic                out_free;
	logic                busy;
	logic                finish;
	logic [IN_BITS-1:0]  in_full;
	logic [W-1:0]        load_mant;
	logic [SCALE_W-1:0]  scale;
	logic [RES_BITS-1:0] mant_low;
	logic                sign_q;
	logic                out_valid_q;
	dnr_ctl_t            ctl;
	dnr_sts_t            sts;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = busy;
	assign out_free  = !out_valid_q || !out_stall;

	// bits at and above WIDE_BITS are dropped, padding up to a whole nibble
	assign in_full   = {mant_word2, mant_word1, mant_word0};
	assign load_mant = W'(in_full[WIDE_BITS-1:0]);

	dnr_ctrl #(
		.NIB       (NIB),
		.MAX_SCALE (MAX_SCALE)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_accept),
		.start_scale (in_scale),
		.out_free    (out_free),
		.sts         (sts),
		.ctl         (ctl),
		.busy        (busy),
		.finish      (finish),
		.scale       (scale)
	);

	dnr_datapath #(
		.NIB (NIB)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.load_mant (load_mant),
		.sts       (sts),
		.mant_low  (mant_low)
	);

	always_ff @(posedge clk) begin
		if (in_accept) sign_q <= in_sign;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_sign <= sign_q;
			if (sts.upper_nz) begin
				res_low    <= '0;
				res_high   <= '0;
				res_scale  <= '0;
				res_status <= sign_q ? STATUS_NEG_OV : STATUS_POS_OV;
			end else begin
				res_low    <= mant_low[63:0];
				res_high   <= mant_low[95:64];
				res_scale  <= scale[RES_SCALE_W-1:0];
				res_status <= STATUS_NORMAL;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/dnr_datapath.sv
`timescale 1ns / 1ps

module dnr_datapath #(
	parameter int NIB = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dnr_pkg::dnr_ctl_t        ctl,
	input  logic [NIB*4-1:0]         load_mant,
	output dnr_pkg::dnr_sts_t        sts,
	output logic [dnr_pkg::RES_BITS-1:0] mant_low
);
	import dnr_pkg::*;

	localparam int W = NIB * 4;

	logic [W-1:0] mant_q, mant_d;
	logic [3:0]   rem_q, rem_d;
	logic         upz_q, upz_d;
	logic         carry_q, carry_d;

	// mantissa rotates left by a nibble while dividing (MSB first),
	// right by a nibble while rounding (LSB first)
	always_comb begin
		logic [7:0]  cur;
		logic [15:0] prod;
		logic [3:0]  qd;
		logic [7:0]  rfull;
		logic [4:0]  sum;
		logic        cin;
		logic        upz_base;
		mant_d   = mant_q;
		rem_d    = rem_q;
		upz_d    = upz_q;
		carry_d  = carry_q;
		cur      = {(ctl.first ? 4'd0 : rem_q), mant_q[W-1 -: 4]};
		prod     = 16'(cur) * 16'd205;  // x*205>>11 == x/10 for x < 1024
		qd       = prod[14:11];
		rfull    = cur - {1'b0, qd, 3'b000} - {3'b000, qd, 1'b0};
		cin      = ctl.first ? sts.round_up : carry_q;
		sum      = {1'b0, mant_q[3:0]} + {4'd0, cin};
		upz_base = ctl.first ? 1'b0 : upz_q;
		unique case (ctl.op)
			OP_LOAD: begin
				mant_d  = load_mant;
				rem_d   = 4'd0;
				upz_d   = |load_mant[W-1:RES_BITS];
				carry_d = 1'b0;
			end
			OP_DIV: begin
				mant_d = {mant_q[W-5:0], qd};
				rem_d  = rfull[3:0];
				upz_d  = upz_base | (ctl.upper & (|qd));
			end
			OP_RND: begin
				mant_d  = {sum[3:0], mant_q[W-1:4]};
				carry_d = sum[4];
				upz_d   = upz_base | (ctl.upper & (|sum[3:0]));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= 4'd0;
			upz_q   <= 1'b0;
			carry_q <= 1'b0;
		end else begin
			rem_q   <= rem_d;
			upz_q   <= upz_d;
			carry_q <= carry_d;
		end
	end

	always_ff @(posedge clk) begin
		mant_q <= mant_d;
	end

	// half to even on the last remainder only
	assign sts.round_up = (rem_q > 4'd5) || ((rem_q == 4'd5) && mant_q[0]);
	assign sts.upper_nz = upz_q;
	assign mant_low     = mant_q[RES_BITS-1:0];

endmodule

### hdl/dnr_ctrl.sv
`timescale 1ns / 1ps

module dnr_ctrl #(
	parameter int NIB       = 48,
	parameter int MAX_SCALE = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dnr_pkg::SCALE_W-1:0]   start_scale,
	input  logic                          out_free,
	input  dnr_pkg::dnr_sts_t             sts,
	output dnr_pkg::dnr_ctl_t             ctl,
	output logic                          busy,
	output logic                          finish,
	output logic [dnr_pkg::SCALE_W-1:0]   scale
);
	import dnr_pkg::*;

	localparam int KW = $clog2(NIB);

	dnr_state_t          state_q, state_d;
	logic [KW-1:0]       k_q, k_d;
	logic [SCALE_W-1:0]  scale_q, scale_d;
	logic                need_div;
	logic                last_nib;

	assign need_div = (sts.upper_nz && (scale_q != '0)) || (scale_q > SCALE_W'(MAX_SCALE));
	assign last_nib = (k_q == KW'(NIB - 1));

	// next state
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		scale_d = scale_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
					scale_d = start_scale;
				end
			end
			ST_CHECK: begin
				k_d = '0;
				if (need_div) begin
					state_d = ST_DIV;
					scale_d = scale_q - SCALE_W'(1);
				end else begin
					state_d = ST_RND;
				end
			end
			ST_DIV: begin
				k_d = k_q + KW'(1);
				if (last_nib) state_d = ST_CHECK;
			end
			ST_RND: begin
				k_d = k_q + KW'(1);
				if (last_nib) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl.op    = OP_IDLE;
		ctl.first = (k_q == '0);
		ctl.upper = 1'b0;
		busy      = 1'b1;
		finish    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) ctl.op = OP_LOAD;
			end
			ST_CHECK: begin
			end
			ST_DIV: begin
				ctl.op    = OP_DIV;
				ctl.upper = (k_q < KW'(NIB - LOW_NIB));
			end
			ST_RND: begin
				ctl.op    = OP_RND;
				ctl.upper = (k_q >= KW'(LOW_NIB));
			end
			ST_DONE: begin
				finish = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			scale_q <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			scale_q <= scale_d;
		end
	end

	assign scale = scale_q;

endmodule

### hdl/dnr_checker.sv
`timescale 1ns / 1ps

module dnr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] res_low,
	input logic [31:0] res_high,
	input logic [4:0]  res_scale,
	input logic        res_sign,
	input logic [1:0]  res_status
);
	import dnr_pkg::*;

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_low) && $stable(res_high)
			&& $stable(res_status))
		else $error("stalled result changed");

	// one item at a time: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted item did not block input");

	// overflow clears the mantissa and scale, status follows sign
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (res_status != STATUS_NORMAL) |->
			res_low == '0 && res_high == '0 && res_scale == '0
			&& (res_status == (res_sign ? STATUS_NEG_OV : STATUS_POS_OV)))
		else $error("bad overflow result");

	a_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (res_status == STATUS_NORMAL) |-> res_scale <= 5'(MAX_SCALE_DEF))
		else $error("result scale out of range");

endmodule

bind decimal_normalize_round_top dnr_checker u_dnr_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for decimal_normalize_round_top.
// Every accepted input item is run through a local model of the scale
// reduction (divide by ten, keep the last digit only, round half to even on
// that digit, then check for overflow) and the expected result is queued.
// Each result taken from the output channel is checked field by field
// against the oldest queued entry.
// Both channels idle and stall at random per item, with stretches of back-to-back
// traffic. The sender drains the block twice (start and middle of the
// random part).
module testbench;

	import dnr_pkg::*;

	localparam int RADIX        = 10;
	localparam int HALF_DIGIT   = 5;
	localparam int MAX_GAP      = 13;
	localparam int RANDOM_ITEMS = 1950;
	// allowances per division pass and per item at 192 bits
	localparam int PASS_CYCLES  = 50;
	localparam int ITEM_CYCLES  = 52;
	localparam int SETTLE       = 200;
	localparam longint CYCLE_FLOOR = 20000;
	localparam logic [IN_BITS-1:0] WIDE_MASK = {IN_BITS{1'b1}} >> (IN_BITS - WIDE_BITS_DEF);

	typedef struct {
		logic [63:0]            low;
		logic [31:0]            high;
		logic [RES_SCALE_W-1:0] scale;
		logic                   sign;
		logic [1:0]             status;
	} rounded_t;

	// Model of the block plus the queue of results it still owes.
	class normalized_results;
		rounded_t awaiting[$];
		int       mismatches;
		longint   budget;

		function new();
			mismatches = 0;
			budget = 0;
		endfunction

		function int count();
			return awaiting.size();
		endfunction

		function void note_item(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
				logic [SCALE_W-1:0] scale_in, logic sign_in);
			logic [IN_BITS-1:0] m;
			logic [3:0]         digit;
			int unsigned        s;
			int unsigned        divs;
			rounded_t           r;
			m = {w2, w1, w0} & WIDE_MASK;
			s = 32'(scale_in);
			digit = '0;
			divs = 0;
			// only the digit of the final division survives
			while ((m[IN_BITS-1:RES_BITS] != 0 && s > 0) || s > MAX_SCALE_DEF) begin
				digit = 4'(m % RADIX);
				m = m / RADIX;
				s--;
				divs++;
			end
			if (digit > HALF_DIGIT || (digit == HALF_DIGIT && m[0]))
				m = m + 1;
			if (m[IN_BITS-1:RES_BITS] != 0) begin
				r.low = '0;
				r.high = '0;
				r.scale = '0;
				r.status = sign_in ? STATUS_NEG_OV : STATUS_POS_OV;
			end else begin
				r.low = m[63:0];
				r.high = m[RES_BITS-1:64];
				r.scale = s[RES_SCALE_W-1:0];
				r.status = STATUS_NORMAL;
			end
			r.sign = sign_in;
			awaiting.push_back(r);
			budget += longint'(ITEM_CYCLES + 2 * MAX_GAP + PASS_CYCLES * (divs + 1));
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_item(logic [63:0] low, logic [31:0] high,
				logic [RES_SCALE_W-1:0] scale, logic sign, logic [1:0] status);
			rounded_t want;
			if (awaiting.size() == 0) begin
				$error("unexpected result: low %0h high %0h scale %0d status %0d",
					low, high, scale, status);
				mismatches++;
				return;
			end
			want = awaiting.pop_front();
			compare_field("res_low", want.low, low);
			compare_field("res_high", want.high, high);
			compare_field("res_scale", want.scale, scale);
			compare_field("res_sign", want.sign, sign);
			compare_field("res_status", want.status, status);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [63:0]            mant_word0;
	logic [63:0]            mant_word1;
	logic [63:0]            mant_word2;
	logic [SCALE_W-1:0]     in_scale;
	logic                   in_sign;
	logic                   out_valid;
	logic                   out_stall;
	logic [63:0]            res_low;
	logic [31:0]            res_high;
	logic [RES_SCALE_W-1:0] res_scale;
	logic                   res_sign;
	logic [1:0]             res_status;

	normalized_results normalized = new();
	longint            cycle_count = 0;
	int                sent_count = 0;
	int                taken_count = 0;

	decimal_normalize_round_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mant_word0 (mant_word0),
		.mant_word1 (mant_word1),
		.mant_word2 (mant_word2),
		.in_scale   (in_scale),
		.in_sign    (in_sign),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res_low    (res_low),
		.res_high   (res_high),
		.res_scale  (res_scale),
		.res_sign   (res_sign),
		.res_status (res_status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: the allowance grows with the division work of each accepted item.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_FLOOR + 4 * normalized.budget) begin
			$display("decimal_normalize_round_top regression: fail");
			$finish;
		end
	end

	// Random mantissa of at most nbits significant bits.
	function automatic logic [IN_BITS-1:0] rand_wide(int unsigned nbits);
		logic [IN_BITS-1:0] v;
		v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (nbits < IN_BITS)
			v &= {IN_BITS{1'b1}} >> (IN_BITS - nbits);
		return v;
	endfunction

	// Called at a rising edge; returns at the edge where the item is taken.
	// With drain set, the sender holds off until the block owes nothing.
	task automatic send_item(input logic [IN_BITS-1:0] mant, input logic [SCALE_W-1:0] scale,
			input logic sign, input bit drain);
		int gap;
		// every fifth stretch of 97 items goes back to back
		gap = ((sent_count / 97) % 5 == 4) ? 0 : $urandom_range(0, MAX_GAP);
		if (drain || gap > 0) begin
			in_valid <= 1'b0;
			if (drain) begin
				do @(posedge clk); while (normalized.count() != 0);
			end
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mant_word0 <= mant[63:0];
		mant_word1 <= mant[127:64];
		mant_word2 <= mant[191:128];
		in_scale <= scale;
		in_sign <= sign;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		normalized.note_item(mant[63:0], mant[127:64], mant[191:128], scale, sign);
		sent_count++;
	endtask

	// Receiver: stall a random number of cycles per item, then take it.
	initial begin
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = ((taken_count / 83) % 5 == 2) ? 0 : $urandom_range(0, MAX_GAP);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			normalized.check_item(res_low, res_high, res_scale, res_sign, res_status);
			taken_count++;
		end
	end

	initial begin
		logic [IN_BITS-1:0] ones96;
		logic [IN_BITS-1:0] mant;
		logic [IN_BITS-1:0] quot;
		logic [IN_BITS-1:0] pow;
		logic [SCALE_W-1:0] scale;
		logic               sign;
		int                 pick;
		int                 k;

		ones96 = {{(IN_BITS - RES_BITS){1'b0}}, {RES_BITS{1'b1}}};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mant_word0 <= '0;
		mant_word1 <= '0;
		mant_word2 <= '0;
		in_scale <= '0;
		in_sign <= 1'b0;
		out_stall <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed items ---
		send_item('0, 8'd0, 1'b0, 1'b0);                   // all zero
		send_item('0, 8'd255, 1'b1, 1'b0);                 // zero, top scale
		send_item(ones96, 8'd0, 1'b0, 1'b0);               // largest that fits
		send_item({IN_BITS{1'b1}}, 8'd0, 1'b0, 1'b0);      // no room to divide: +ovf
		send_item({IN_BITS{1'b1}}, 8'd0, 1'b1, 1'b0);      // same, -ovf
		send_item({IN_BITS{1'b1}}, 8'd28, 1'b1, 1'b0);     // scale runs out first
		send_item({IN_BITS{1'b1}}, 8'd255, 1'b0, 1'b0);    // divides down to nothing
		send_item(192'd1, 8'd29, 1'b0, 1'b0);              // one forced division
		send_item(192'd45, 8'd29, 1'b0, 1'b0);             // tie, even quotient stays
		send_item(192'd35, 8'd29, 1'b1, 1'b0);             // tie, odd quotient rounds up
		send_item(192'd46, 8'd29, 1'b0, 1'b0);             // above half
		send_item(192'd44, 8'd29, 1'b1, 1'b0);             // below half
		send_item(192'd2459, 8'd30, 1'b0, 1'b0);           // earlier 9 must not count
		send_item(ones96 * RADIX + 6, 8'd1, 1'b1, 1'b0);   // rounding carries past 96
		send_item(ones96 * RADIX + 6, 8'd1, 1'b0, 1'b0);
		send_item(ones96 * RADIX + 4, 8'd1, 1'b0, 1'b0);   // just fits
		send_item(192'd1 << RES_BITS, 8'd5, 1'b0, 1'b0);   // bit 96 alone
		send_item(192'd1 << (IN_BITS - 1), 8'd28, 1'b1, 1'b0);
		send_item(rand_wide(RES_BITS), 8'd28, 1'b1, 1'b0); // fits at max scale
		send_item(192'd12345, 8'd128, 1'b0, 1'b0);

		// --- random items ---
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			sign = 1'($urandom_range(0, 1));
			if (pick < 40) begin
				// already fits, nothing to do
				mant = rand_wide($urandom_range(0, RES_BITS));
				scale = SCALE_W'($urandom_range(0, MAX_SCALE_DEF));
			end else if (pick < 62) begin
				// too wide; overflows when the scale runs out
				mant = rand_wide($urandom_range(RES_BITS + 1, IN_BITS));
				scale = SCALE_W'($urandom_range(0, 40));
			end else if (pick < 82) begin
				// quotient, final digit, then k junk digits that get dropped
				quot = ($urandom_range(0, 7) == 0) ? ones96
					: rand_wide($urandom_range(1, RES_BITS));
				mant = quot * RADIX + $urandom_range(0, RADIX - 1);
				k = $urandom_range(0, 3);
				pow = 1;
				repeat (k) pow = pow * RADIX;
				mant = mant * pow + ($urandom % pow);
				if (k == 0 && mant[IN_BITS-1:RES_BITS] != 0 && $urandom_range(0, 1))
					scale = SCALE_W'($urandom_range(1, MAX_SCALE_DEF));
				else
					scale = SCALE_W'(MAX_SCALE_DEF + 1 + k);
			end else if (pick < 92) begin
				// scale above the maximum forces divisions
				mant = rand_wide($urandom_range(0, 110));
				scale = SCALE_W'($urandom_range(MAX_SCALE_DEF + 1, 50));
			end else begin
				case ($urandom_range(0, 3))
					0: mant = '0;
					1: mant = {IN_BITS{1'b1}};
					default: mant = rand_wide(IN_BITS);
				endcase
				scale = SCALE_W'(($urandom_range(0, 99) == 0) ? $urandom_range(41, 255)
					: $urandom_range(0, 40));
			end
			send_item(mant, scale, sign, i == 0 || i == RANDOM_ITEMS / 2);
		end
		in_valid <= 1'b0;

		while (normalized.count() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (normalized.mismatches == 0)
			$display("decimal_normalize_round_top regression: pass");
		else
			$display("decimal_normalize_round_top regression: fail");
		$finish;
	end

endmodule
